// ===== design/binary_grid_majority_smoother_defines.svh =====
// Assertion macros shared by the smoother modules.
`ifndef BINARY_GRID_MAJORITY_SMOOTHER_DEFINES_SVH
`define BINARY_GRID_MAJORITY_SMOOTHER_DEFINES_SVH

`ifndef ASSERT_OFF
`define BGMS_ASSERT_ALWAYS(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
    else $error("assertion failed");
`define BGMS_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define BGMS_ASSERT_ALWAYS(lbl, ck, rn, expr)
`define BGMS_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== design/bgms_pkg.sv =====
`timescale 1ns / 1ps
package bgms_pkg;

  localparam int W_REG_W    = 6;
  localparam int H_REG_W    = 11;
  localparam int T_REG_W    = 4;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_W      = 10;
  localparam int OUT_COL_W  = 5;
  localparam int CNT_W      = 4;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_THRESHOLD = 2'd2;

  localparam logic [W_REG_W-1:0] WIDTH_RESET     = 6'd25;
  localparam logic [H_REG_W-1:0] HEIGHT_RESET    = 11'd25;
  localparam logic [T_REG_W-1:0] THRESHOLD_RESET = 4'd5;
  localparam logic [H_REG_W-1:0] MAX_HEIGHT      = 11'd1024;

  // Emit kinds, in the order their results leave the block.
  localparam int EMIT_UP_MID   = 0;
  localparam int EMIT_UP_END   = 1;
  localparam int EMIT_LAST_MID = 2;
  localparam int EMIT_LAST_END = 3;
  localparam int EMIT_N        = 4;

  localparam logic [1:0] SLOT_0 = 2'd0;
  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;

  // Window rows: 0 is two rows up, 2 is the current row. Column 2 is the newest.
  typedef logic [2:0][2:0] win_t;

  typedef struct packed {
    win_t                  win;
    logic [ROW_W-1:0]      row;
    logic [OUT_COL_W-1:0]  col;
    logic [EMIT_N-1:0]     emit;
  } entry_t;

endpackage

// ===== design/binary_grid_majority_smoother.sv =====
`timescale 1ns / 1ps
// Binary 3x3 majority smoother. Cells of a grid enter in raster order, one bit
// per word on the in_ channel, and each smoothed cell leaves as one word on the
// out_ channel with its row, column, a last-of-run flag and an end-of-grid flag.
// A cell is set when the set cells of its 3x3 window reach fill_threshold.
// The configuration port writes grid_width, grid_height and fill_threshold by
// index. A write to one of them restarts the grid at cell (0,0); any write
// must be made while idle. A cell's result comes out once its lower neighbors
// are in: nothing during the first row or at a row's first cell, one result
// per input otherwise and two in the last row, two at a row end, and four for
// the final cell. A result passes through the four-entry queue between front
// and back and then the output register before it is presented. The back end
// writes one result per cycle into the output register while the receiver
// keeps up; the queue absorbs inputs while extra results drain.
// Reset sets the registers to 25, 25 and 5 and starts at cell (0,0). While the
// receiver stalls the output holds, the queue fills and in_ready falls.
module binary_grid_majority_smoother #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bgms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bgms_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cell_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_cell_out,
  output logic [bgms_pkg::ROW_W-1:0]           out_row,
  output logic [bgms_pkg::OUT_COL_W-1:0]       out_col,
  output logic                                 out_last_of_run,
  output logic                                 out_end_of_grid
);
  import bgms_pkg::*;

  logic [W_REG_W-1:0] grid_width_r;
  logic [H_REG_W-1:0] grid_height_r;
  logic [T_REG_W-1:0] fill_threshold_r;
  logic [W_REG_W-1:0] w_eff;
  logic [H_REG_W-1:0] h_eff;
  logic               restart;
  logic               q_full, q_empty, push, pop;
  entry_t             push_entry, head;

  always_comb begin
    unique case (cfg_index)
      REG_GRID_WIDTH, REG_GRID_HEIGHT, REG_FILL_THRESHOLD: restart = cfg_we;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r     <= WIDTH_RESET;
      grid_height_r    <= HEIGHT_RESET;
      fill_threshold_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:     grid_width_r     <= cfg_data[W_REG_W-1:0];
        REG_GRID_HEIGHT:    grid_height_r    <= cfg_data[H_REG_W-1:0];
        REG_FILL_THRESHOLD: fill_threshold_r <= cfg_data[T_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (grid_width_r == '0) ? W_REG_W'(1) :
                 (grid_width_r > W_REG_W'(MAX_WIDTH)) ? W_REG_W'(MAX_WIDTH) : grid_width_r;
  assign h_eff = (grid_height_r == '0) ? H_REG_W'(1) :
                 (grid_height_r > MAX_HEIGHT) ? MAX_HEIGHT : grid_height_r;

  bgms_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cell_in (in_cell_in),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  bgms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .empty      (q_empty),
    .pop        (pop),
    .head       (head)
  );

  bgms_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .threshold       (fill_threshold_r),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cell_out    (out_cell_out),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .out_end_of_grid (out_end_of_grid)
  );

endmodule

// ===== design/bgms_front.sv =====
`timescale 1ns / 1ps
`include "binary_grid_majority_smoother_defines.svh"
module bgms_front #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           restart,
  input  logic [bgms_pkg::W_REG_W-1:0]   w_eff,
  input  logic [bgms_pkg::H_REG_W-1:0]   h_eff,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cell_in,
  input  logic                           q_full,
  output logic                           push,
  output bgms_pkg::entry_t               push_entry
);
  import bgms_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [2:0]       col_mem_r [MAX_WIDTH];
  logic [COL_W-1:0] col_count_r, col_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [1:0]       slot_r, slot_nxt;
  logic [2:0]       strip1_r, strip2_r;

  logic [2:0] col_word;
  logic [2:0] cur_col, prev1, prev2;
  logic [1:0] slot_m1, slot_m2;
  logic       r_ge1, r_ge2, c_ge1, c_ge2, c_last, r_last;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign col_word = col_mem_r[col_count_r];

  always_comb begin
    unique case (slot_r)
      SLOT_0: begin
        slot_m1 = SLOT_2;
        slot_m2 = SLOT_1;
      end
      SLOT_1: begin
        slot_m1 = SLOT_0;
        slot_m2 = SLOT_2;
      end
      default: begin
        slot_m1 = SLOT_1;
        slot_m2 = SLOT_0;
      end
    endcase
  end

  assign r_ge1  = row_count_r != '0;
  assign r_ge2  = row_count_r > ROW_W'(1);
  assign c_ge1  = col_count_r != '0;
  assign c_ge2  = col_count_r > COL_W'(1);
  assign c_last = W_REG_W'(col_count_r) == (w_eff - W_REG_W'(1));
  assign r_last = H_REG_W'(row_count_r) == (h_eff - H_REG_W'(1));

  assign cur_col = {in_cell_in, r_ge1 && col_word[slot_m1], r_ge2 && col_word[slot_m2]};
  assign prev1   = c_ge1 ? strip1_r : 3'b000;
  assign prev2   = c_ge2 ? strip2_r : 3'b000;

  always_comb begin
    push_entry     = '0;
    for (int rr = 0; rr < 3; rr++) begin
      push_entry.win[rr][0] = prev2[rr];
      push_entry.win[rr][1] = prev1[rr];
      push_entry.win[rr][2] = cur_col[rr];
    end
    push_entry.row = row_count_r;
    push_entry.col = OUT_COL_W'(col_count_r);
    push_entry.emit[EMIT_UP_MID]   = r_ge1 && c_ge1;
    push_entry.emit[EMIT_UP_END]   = r_ge1 && c_last;
    push_entry.emit[EMIT_LAST_MID] = r_last && c_ge1;
    push_entry.emit[EMIT_LAST_END] = r_last && c_last;
  end

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    slot_nxt      = slot_r;
    if (restart) begin
      col_count_nxt = '0;
      row_count_nxt = '0;
      slot_nxt      = SLOT_0;
    end else if (push) begin
      if (c_last) begin
        col_count_nxt = '0;
        if (r_last) begin
          row_count_nxt = '0;
          slot_nxt      = SLOT_0;
        end else begin
          row_count_nxt = row_count_r + ROW_W'(1);
          slot_nxt      = (slot_r == SLOT_2) ? SLOT_0 : slot_r + 2'd1;
        end
      end else begin
        col_count_nxt = col_count_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      slot_r      <= SLOT_0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      slot_r      <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      col_mem_r[col_count_r][slot_r] <= in_cell_in;
      strip1_r <= cur_col;
      strip2_r <= strip1_r;
    end
  end

  `BGMS_ASSERT_ALWAYS(a_col_in_range, clk, rst_n, W_REG_W'(col_count_r) < w_eff)
  `BGMS_ASSERT_ALWAYS(a_row_in_range, clk, rst_n, H_REG_W'(row_count_r) < h_eff)

endmodule

// ===== design/bgms_queue.sv =====
`timescale 1ns / 1ps
`include "binary_grid_majority_smoother_defines.svh"
module bgms_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bgms_pkg::entry_t  push_entry,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output bgms_pkg::entry_t  head
);
  import bgms_pkg::*;

  entry_t             slots_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign full  = count_r == Q_CNT_W'(Q_DEPTH);
  assign empty = count_r == '0;
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  `BGMS_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full)
  `BGMS_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, !empty)

endmodule

// ===== design/bgms_back.sv =====
`timescale 1ns / 1ps
`include "binary_grid_majority_smoother_defines.svh"
module bgms_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [bgms_pkg::T_REG_W-1:0]      threshold,
  input  logic                              q_empty,
  input  bgms_pkg::entry_t                  head,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_cell_out,
  output logic [bgms_pkg::ROW_W-1:0]        out_row,
  output logic [bgms_pkg::OUT_COL_W-1:0]    out_col,
  output logic                              out_last_of_run,
  output logic                              out_end_of_grid
);
  import bgms_pkg::*;

  function automatic logic [CNT_W-1:0] win_count(win_t win, logic [2:0] use_row,
                                                 logic [2:0] use_col);
    logic [CNT_W-1:0] sum;
    sum = '0;
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 3; cc++) begin
        sum = sum + CNT_W'(win[rr][cc] && use_row[rr] && use_col[cc]);
      end
    end
    return sum;
  endfunction

  entry_t              work_r, work_nxt, src;
  logic                work_busy_r;
  logic                out_valid_r;
  logic                cell_r, last_r, end_r;
  logic [ROW_W-1:0]    row_r;
  logic [OUT_COL_W-1:0] col_r;

  logic                src_vld, slot_free, emit;
  logic [EMIT_N-1:0]   sel, remaining;
  logic                is_upper, is_end;
  logic [CNT_W-1:0]    count;

  assign src_vld   = work_busy_r || !q_empty;
  assign src       = work_busy_r ? work_r : head;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    sel = '0;
    priority if (src.emit[EMIT_UP_MID]) begin
      sel[EMIT_UP_MID] = 1'b1;
    end else if (src.emit[EMIT_UP_END]) begin
      sel[EMIT_UP_END] = 1'b1;
    end else if (src.emit[EMIT_LAST_MID]) begin
      sel[EMIT_LAST_MID] = 1'b1;
    end else if (src.emit[EMIT_LAST_END]) begin
      sel[EMIT_LAST_END] = 1'b1;
    end else begin
      sel = '0;
    end
  end

  assign remaining = src.emit & ~sel;
  assign is_upper  = sel[EMIT_UP_MID] || sel[EMIT_UP_END];
  assign is_end    = sel[EMIT_UP_END] || sel[EMIT_LAST_END];
  assign count     = win_count(src.win, {2'b11, is_upper}, {2'b11, !is_end});
  assign emit      = src_vld && (src.emit != '0) && slot_free;
  assign pop       = !work_busy_r && !q_empty && ((head.emit == '0) || slot_free);

  always_comb begin
    work_nxt      = src;
    work_nxt.emit = remaining;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_busy_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        work_busy_r <= remaining != '0;
      end
      out_valid_r <= emit || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      work_r      <= work_nxt;
      cell_r      <= count >= threshold;
      row_r       <= is_upper ? src.row - ROW_W'(1) : src.row;
      col_r       <= is_end ? src.col : src.col - OUT_COL_W'(1);
      last_r      <= remaining == '0;
      end_r       <= sel[EMIT_LAST_END];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_out    = cell_r;
  assign out_row         = row_r;
  assign out_col         = col_r;
  assign out_last_of_run = last_r;
  assign out_end_of_grid = end_r;

  `BGMS_ASSERT_IMPLY(a_busy_has_work, clk, rst_n, work_busy_r, work_r.emit != '0)

endmodule
